### hw/rtl/rsbb_pkg.sv
package rsbb_pkg;

   localparam int COORD_BITS_DEF      = 18;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int SIZE_BITS  = 12;
   localparam int PIVOT_BITS = 16;
   localparam int SCALE_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int POS_BITS   = 17;

   localparam int PIVOT_FRAC = 14;
   localparam int PROD_FRAC  = 23;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIVX,
      ST_PIVY,
      ST_SCLX,
      ST_SCLY,
      ST_RX0,
      ST_RX1,
      ST_RY0,
      ST_RY1,
      ST_CRN0,
      ST_CRN1,
      ST_CRN2,
      ST_CRN3,
      ST_MERGE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PIVX,
      OP_PIVY,
      OP_SCLX,
      OP_SCLY,
      OP_RX0,
      OP_RX1,
      OP_RY0,
      OP_RY1,
      OP_CRN,
      OP_MERGE
   } op_type;

   typedef struct packed {
      logic       load;
      op_type     op;
      logic [1:0] corner;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // sin(pi/2 * m / 2^(tb-2)) in q15, taylor series in q30
   function automatic logic [15:0] quarter_sine(input int unsigned m, input int unsigned tb);
      longint unsigned theta;
      longint unsigned th2;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned r;
      int unsigned     k;
      theta = (HALF_PI_Q30 * longint'(m)) >> (tb - 2);
      th2   = (theta * theta) >> 30;
      term  = theta;
      pos   = theta;
      neg   = 64'd0;
      for (k = 1; k <= 5; k++) begin
         term = (term * th2) >> 30;
         unique case (k)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            default: term = term / 64'd110;
         endcase
         if (k % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      r = (pos > neg) ? pos - neg : 64'd0;
      if (r > ONE_Q30) begin
         r = ONE_Q30;
      end
      return 16'((r + 64'd16384) >> 15);
   endfunction

endpackage

### hw/rtl/rsbb_req_if.sv
interface rsbb_req_if;
   import rsbb_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [SIZE_BITS-1:0]  sprite_width;
   logic        [SIZE_BITS-1:0]  sprite_height;
   logic signed [PIVOT_BITS-1:0] pivot_x;
   logic signed [PIVOT_BITS-1:0] pivot_y;
   logic signed [SCALE_BITS-1:0] scale_x;
   logic signed [SCALE_BITS-1:0] scale_y;
   logic        [ANGLE_BITS-1:0] angle;
   logic signed [POS_BITS-1:0]   pos_x;
   logic signed [POS_BITS-1:0]   pos_y;
   logic                         start_frame;

   modport source (
      output valid, sprite_width, sprite_height, pivot_x, pivot_y, scale_x, scale_y,
             angle, pos_x, pos_y, start_frame,
      input  ready
   );

   modport sink (
      input  valid, sprite_width, sprite_height, pivot_x, pivot_y, scale_x, scale_y,
             angle, pos_x, pos_y, start_frame,
      output ready
   );

endinterface

### hw/rtl/rsbb_rsp_if.sv
interface rsbb_rsp_if #(
   parameter int COORD_BITS = rsbb_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] box_left;
   logic signed [COORD_BITS-1:0] box_top;
   logic signed [COORD_BITS-1:0] box_right;
   logic signed [COORD_BITS-1:0] box_bottom;
   logic signed [COORD_BITS-1:0] union_left;
   logic signed [COORD_BITS-1:0] union_top;
   logic signed [COORD_BITS-1:0] union_right;
   logic signed [COORD_BITS-1:0] union_bottom;

   modport source (
      output valid, box_left, box_top, box_right, box_bottom,
             union_left, union_top, union_right, union_bottom,
      input  ready
   );

   modport sink (
      input  valid, box_left, box_top, box_right, box_bottom,
             union_left, union_top, union_right, union_bottom,
      output ready
   );

endinterface

### hw/rtl/rsbb_ctrl.sv
module rsbb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rsbb_pkg::status_type   status,
   output rsbb_pkg::cmd_type      cmd
);
   import rsbb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.op     = OP_NONE;
      cmd.corner = 2'd0;
      unique case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_PIVX;
            end
         end
         ST_PIVX: begin
            cmd.op   = OP_PIVX;
            state_in = ST_PIVY;
         end
         ST_PIVY: begin
            cmd.op   = OP_PIVY;
            state_in = ST_SCLX;
         end
         ST_SCLX: begin
            cmd.op   = OP_SCLX;
            state_in = ST_SCLY;
         end
         ST_SCLY: begin
            cmd.op   = OP_SCLY;
            state_in = ST_RX0;
         end
         ST_RX0: begin
            cmd.op   = OP_RX0;
            state_in = ST_RX1;
         end
         ST_RX1: begin
            cmd.op   = OP_RX1;
            state_in = ST_RY0;
         end
         ST_RY0: begin
            cmd.op   = OP_RY0;
            state_in = ST_RY1;
         end
         ST_RY1: begin
            cmd.op   = OP_RY1;
            state_in = ST_CRN0;
         end
         ST_CRN0: begin
            cmd.op     = OP_CRN;
            cmd.corner = 2'd0;
            state_in   = ST_CRN1;
         end
         ST_CRN1: begin
            cmd.op     = OP_CRN;
            cmd.corner = 2'd1;
            state_in   = ST_CRN2;
         end
         ST_CRN2: begin
            cmd.op     = OP_CRN;
            cmd.corner = 2'd2;
            state_in   = ST_CRN3;
         end
         ST_CRN3: begin
            cmd.op     = OP_CRN;
            cmd.corner = 2'd3;
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            // wait until the output register can take the word
            if (!status.out_busy) begin
               cmd.op   = OP_MERGE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/rsbb_dp.sv
module rsbb_dp #(
   parameter int COORD_BITS      = rsbb_pkg::COORD_BITS_DEF,
   parameter int SINE_TABLE_BITS = rsbb_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rsbb_pkg::cmd_type                      cmd,
   output rsbb_pkg::status_type                   status,
   input  logic        [rsbb_pkg::SIZE_BITS-1:0]  sprite_width,
   input  logic        [rsbb_pkg::SIZE_BITS-1:0]  sprite_height,
   input  logic signed [rsbb_pkg::PIVOT_BITS-1:0] pivot_x,
   input  logic signed [rsbb_pkg::PIVOT_BITS-1:0] pivot_y,
   input  logic signed [rsbb_pkg::SCALE_BITS-1:0] scale_x,
   input  logic signed [rsbb_pkg::SCALE_BITS-1:0] scale_y,
   input  logic        [rsbb_pkg::ANGLE_BITS-1:0] angle,
   input  logic signed [rsbb_pkg::POS_BITS-1:0]   pos_x,
   input  logic signed [rsbb_pkg::POS_BITS-1:0]   pos_y,
   input  logic                                   start_frame,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [COORD_BITS-1:0]           box_left,
   output logic signed [COORD_BITS-1:0]           box_top,
   output logic signed [COORD_BITS-1:0]           box_right,
   output logic signed [COORD_BITS-1:0]           box_bottom,
   output logic signed [COORD_BITS-1:0]           union_left,
   output logic signed [COORD_BITS-1:0]           union_top,
   output logic signed [COORD_BITS-1:0]           union_right,
   output logic signed [COORD_BITS-1:0]           union_bottom
);
   import rsbb_pkg::*;

   localparam int TB   = SINE_TABLE_BITS;
   localparam int QTR  = 2 ** (TB - 2);
   localparam int MA   = 31;
   localparam int MB   = 17;
   localparam int MP   = MA + MB;
   localparam int OW   = 15;
   localparam int SUMW = MP + 1;
   localparam int PW   = SUMW - PROD_FRAC;
   localparam int CW   = PW + 1;
   localparam int EW   = (COORD_BITS > CW) ? COORD_BITS : CW;

   localparam logic        [TB-1:0]         QTR_IDX   = TB'(QTR);
   localparam logic        [TB-2:0]         QTR_M     = (TB - 1)'(QTR);
   localparam logic signed [MB-1:0]         PIVOT_ONE = MB'(2 ** PIVOT_FRAC);
   localparam logic signed [MP-1:0]         PIV_ADJ   = MP'(2 ** PIVOT_FRAC - 1);
   localparam logic signed [SUMW-1:0]       PROD_ADJ  = SUMW'(2 ** PROD_FRAC - 1);
   localparam logic signed [COORD_BITS-1:0] CMAX      = {1'b0, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN      = {1'b1, {(COORD_BITS - 1){1'b0}}};

   // captured word
   logic        [SIZE_BITS-1:0]  w_ff;
   logic        [SIZE_BITS-1:0]  h_ff;
   logic signed [PIVOT_BITS-1:0] px_ff;
   logic signed [PIVOT_BITS-1:0] py_ff;
   logic signed [SCALE_BITS-1:0] sx_ff;
   logic signed [SCALE_BITS-1:0] sy_ff;
   logic        [TB-1:0]         idx_ff;
   logic signed [POS_BITS-1:0]   posx_ff;
   logic signed [POS_BITS-1:0]   posy_ff;
   logic                         start_ff;

   logic signed [MP-1:0] p0_ff;
   logic signed [MP-1:0] p1_ff;
   logic signed [MP-1:0] p0_in;
   logic signed [MP-1:0] p1_in;
   logic signed [MB-1:0] sin_ff;
   logic signed [MB-1:0] cos_ff;
   logic signed [OW-1:0] nx_ff;
   logic signed [OW-1:0] fx_ff;
   logic signed [OW-1:0] ny_ff;
   logic signed [OW-1:0] fy_ff;
   logic signed [MA-1:0] ax_ff [2];
   logic signed [MA-1:0] ay_ff [2];
   logic signed [MP-1:0] xc_ff [2];
   logic signed [MP-1:0] xs_ff [2];
   logic signed [MP-1:0] ys_ff [2];
   logic signed [MP-1:0] yc_ff [2];

   logic signed [COORD_BITS-1:0] l_ff;
   logic signed [COORD_BITS-1:0] t_ff;
   logic signed [COORD_BITS-1:0] r_ff;
   logic signed [COORD_BITS-1:0] b_ff;
   logic signed [COORD_BITS-1:0] accl_ff;
   logic signed [COORD_BITS-1:0] acct_ff;
   logic signed [COORD_BITS-1:0] accr_ff;
   logic signed [COORD_BITS-1:0] accb_ff;
   logic signed [COORD_BITS-1:0] accl_in;
   logic signed [COORD_BITS-1:0] acct_in;
   logic signed [COORD_BITS-1:0] accr_in;
   logic signed [COORD_BITS-1:0] accb_in;
   logic signed [COORD_BITS-1:0] outbl_ff;
   logic signed [COORD_BITS-1:0] outbt_ff;
   logic signed [COORD_BITS-1:0] outbr_ff;
   logic signed [COORD_BITS-1:0] outbb_ff;
   logic signed [COORD_BITS-1:0] outul_ff;
   logic signed [COORD_BITS-1:0] outut_ff;
   logic signed [COORD_BITS-1:0] outur_ff;
   logic signed [COORD_BITS-1:0] outub_ff;
   logic                         outv_ff;

   // sine lookup
   logic        [15:0]   qtr_lut [QTR + 1];
   logic        [TB-1:0] lut_idx;
   logic        [1:0]    lut_q;
   logic        [TB-3:0] lut_r;
   logic        [TB-2:0] lut_m;
   logic signed [MB-1:0] lut_mag;
   logic signed [MB-1:0] lut_val;

   logic signed [MA-1:0] a0;
   logic signed [MA-1:0] a1;
   logic signed [MB-1:0] b0;
   logic signed [MB-1:0] b1;

   logic                         ix;
   logic                         iy;
   logic signed [SUMW-1:0]       xsum;
   logic signed [SUMW-1:0]       ysum;
   logic signed [PW-1:0]         xq;
   logic signed [PW-1:0]         yq;
   logic signed [COORD_BITS-1:0] ox;
   logic signed [COORD_BITS-1:0] oy;
   logic signed [COORD_BITS-1:0] base_l;
   logic signed [COORD_BITS-1:0] base_t;
   logic signed [COORD_BITS-1:0] base_r;
   logic signed [COORD_BITS-1:0] base_b;

   function automatic logic signed [OW-1:0] piv_off(input logic signed [MP-1:0] v);
      logic signed [MP-1:0] adj;
      adj = v + (v[MP-1] ? PIV_ADJ : '0);
      return OW'(adj >>> PIVOT_FRAC);
   endfunction

   function automatic logic signed [PW-1:0] prod_trunc(input logic signed [SUMW-1:0] v);
      logic signed [SUMW-1:0] adj;
      adj = v + (v[SUMW-1] ? PROD_ADJ : '0);
      return PW'(adj >>> PROD_FRAC);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [CW-1:0] v);
      logic signed [EW-1:0] ve;
      ve = EW'(v);
      if (ve > EW'(CMAX)) begin
         return CMAX;
      end else if (ve < EW'(CMIN)) begin
         return CMIN;
      end
      return COORD_BITS'(ve);
   endfunction

   genvar g;
   generate
      for (g = 0; g <= QTR; g++) begin : g_lut
         assign qtr_lut[g] = quarter_sine(g, TB);
      end
   endgenerate

   always_comb begin
      lut_idx = (cmd.op == OP_PIVY) ? idx_ff + QTR_IDX : idx_ff;
      lut_q   = lut_idx[TB-1 -: 2];
      lut_r   = lut_idx[TB-3:0];
      lut_m   = lut_q[0] ? QTR_M - {1'b0, lut_r} : {1'b0, lut_r};
      lut_mag = {1'b0, qtr_lut[lut_m]};
      lut_val = lut_q[1] ? -lut_mag : lut_mag;
   end

   // two shared multipliers, operands picked per step
   always_comb begin
      a0 = '0;
      a1 = '0;
      b0 = '0;
      b1 = '0;
      unique case (cmd.op)
         OP_PIVX: begin
            a0 = {{(MA - SIZE_BITS){1'b0}}, w_ff};
            a1 = {{(MA - SIZE_BITS){1'b0}}, w_ff};
            b0 = MB'(px_ff);
            b1 = PIVOT_ONE - MB'(px_ff);
         end
         OP_PIVY: begin
            a0 = {{(MA - SIZE_BITS){1'b0}}, h_ff};
            a1 = {{(MA - SIZE_BITS){1'b0}}, h_ff};
            b0 = MB'(py_ff);
            b1 = PIVOT_ONE - MB'(py_ff);
         end
         OP_SCLX: begin
            a0 = -MA'(nx_ff);
            a1 = MA'(fx_ff);
            b0 = MB'(sx_ff);
            b1 = MB'(sx_ff);
         end
         OP_SCLY: begin
            a0 = -MA'(ny_ff);
            a1 = MA'(fy_ff);
            b0 = MB'(sy_ff);
            b1 = MB'(sy_ff);
         end
         OP_RX0: begin
            a0 = ax_ff[0];
            a1 = ax_ff[0];
            b0 = cos_ff;
            b1 = sin_ff;
         end
         OP_RX1: begin
            a0 = ax_ff[1];
            a1 = ax_ff[1];
            b0 = cos_ff;
            b1 = sin_ff;
         end
         OP_RY0: begin
            a0 = ay_ff[0];
            a1 = ay_ff[0];
            b0 = sin_ff;
            b1 = cos_ff;
         end
         OP_RY1: begin
            a0 = ay_ff[1];
            a1 = ay_ff[1];
            b0 = sin_ff;
            b1 = cos_ff;
         end
         default: begin
         end
      endcase
      p0_in = MP'(a0) * MP'(b0);
      p1_in = MP'(a1) * MP'(b1);
   end

   // one corner: ix picks near/far x, iy picks near/far y
   always_comb begin
      ix   = cmd.corner[1];
      iy   = cmd.corner[0];
      xsum = SUMW'(xc_ff[ix]) + SUMW'(ys_ff[iy]);
      ysum = SUMW'(yc_ff[iy]) - SUMW'(xs_ff[ix]);
      xq   = prod_trunc(xsum);
      yq   = prod_trunc(ysum);
      ox   = sat(CW'(xq) + CW'(posx_ff));
      oy   = sat(CW'(yq) + CW'(posy_ff));
   end

   always_comb begin
      base_l  = start_ff ? CMAX : accl_ff;
      base_t  = start_ff ? CMAX : acct_ff;
      base_r  = start_ff ? CMIN : accr_ff;
      base_b  = start_ff ? CMIN : accb_ff;
      accl_in = (l_ff < base_l) ? l_ff : base_l;
      acct_in = (t_ff < base_t) ? t_ff : base_t;
      accr_in = (r_ff > base_r) ? r_ff : base_r;
      accb_in = (b_ff > base_b) ? b_ff : base_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff     <= sprite_width;
         h_ff     <= sprite_height;
         px_ff    <= pivot_x;
         py_ff    <= pivot_y;
         sx_ff    <= scale_x;
         sy_ff    <= scale_y;
         idx_ff   <= angle[ANGLE_BITS-1 -: TB];
         posx_ff  <= pos_x;
         posy_ff  <= pos_y;
         start_ff <= start_frame;
      end
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      unique case (cmd.op)
         OP_PIVX: begin
            sin_ff <= lut_val;
         end
         OP_PIVY: begin
            cos_ff <= lut_val;
            nx_ff  <= piv_off(p0_ff);
            fx_ff  <= piv_off(p1_ff);
         end
         OP_SCLX: begin
            ny_ff <= piv_off(p0_ff);
            fy_ff <= piv_off(p1_ff);
         end
         OP_SCLY: begin
            ax_ff[0] <= MA'(p0_ff);
            ax_ff[1] <= MA'(p1_ff);
         end
         OP_RX0: begin
            ay_ff[0] <= MA'(p0_ff);
            ay_ff[1] <= MA'(p1_ff);
         end
         OP_RX1: begin
            xc_ff[0] <= p0_ff;
            xs_ff[0] <= p1_ff;
         end
         OP_RY0: begin
            xc_ff[1] <= p0_ff;
            xs_ff[1] <= p1_ff;
         end
         OP_RY1: begin
            ys_ff[0] <= p0_ff;
            yc_ff[0] <= p1_ff;
         end
         OP_CRN: begin
            if (cmd.corner == 2'd0) begin
               ys_ff[1] <= p0_ff;
               yc_ff[1] <= p1_ff;
               l_ff     <= ox;
               r_ff     <= ox;
               t_ff     <= oy;
               b_ff     <= oy;
            end else begin
               l_ff <= (ox < l_ff) ? ox : l_ff;
               r_ff <= (ox > r_ff) ? ox : r_ff;
               t_ff <= (oy < t_ff) ? oy : t_ff;
               b_ff <= (oy > b_ff) ? oy : b_ff;
            end
         end
         OP_MERGE: begin
            outbl_ff <= l_ff;
            outbt_ff <= t_ff;
            outbr_ff <= r_ff;
            outbb_ff <= b_ff;
            outul_ff <= accl_in;
            outut_ff <= acct_in;
            outur_ff <= accr_in;
            outub_ff <= accb_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accl_ff <= CMAX;
         acct_ff <= CMAX;
         accr_ff <= CMIN;
         accb_ff <= CMIN;
         outv_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_MERGE) begin
            accl_ff <= accl_in;
            acct_ff <= acct_in;
            accr_ff <= accr_in;
            accb_ff <= accb_in;
            outv_ff <= 1'b1;
         end else if (rsp_ready) begin
            outv_ff <= 1'b0;
         end
      end
   end

   assign status.out_busy = outv_ff && !rsp_ready;
   assign rsp_valid       = outv_ff;
   assign box_left        = outbl_ff;
   assign box_top         = outbt_ff;
   assign box_right       = outbr_ff;
   assign box_bottom      = outbb_ff;
   assign union_left      = outul_ff;
   assign union_top       = outut_ff;
   assign union_right     = outur_ff;
   assign union_bottom    = outub_ff;

endmodule

### hw/rtl/rotated_sprite_bounding_box_core.sv
// one sprite at a time: a new request word is taken only in idle, after the merge step
// of the last sprite; two shared multipliers step through eight product steps,
// then four corner steps and one merge step
// the result sits in an output register, so the next sprite is taken while it waits;
// the merge step waits only while a previous result word is still unaccepted
// reset (synchronous): controller idle, output empty, union rectangle set to empty
module rotated_sprite_bounding_box_core #(
   parameter int COORD_BITS      = rsbb_pkg::COORD_BITS_DEF,
   parameter int SINE_TABLE_BITS = rsbb_pkg::SINE_TABLE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rsbb_req_if.sink   req_port,
   rsbb_rsp_if.source rsp_port
);
   import rsbb_pkg::*;

   cmd_type    cmd;
   status_type status;

   rsbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsbb_dp #(
      .COORD_BITS      (COORD_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sprite_width  (req_port.sprite_width),
      .sprite_height (req_port.sprite_height),
      .pivot_x       (req_port.pivot_x),
      .pivot_y       (req_port.pivot_y),
      .scale_x       (req_port.scale_x),
      .scale_y       (req_port.scale_y),
      .angle         (req_port.angle),
      .pos_x         (req_port.pos_x),
      .pos_y         (req_port.pos_y),
      .start_frame   (req_port.start_frame),
      .rsp_ready     (rsp_port.ready),
      .rsp_valid     (rsp_port.valid),
      .box_left      (rsp_port.box_left),
      .box_top       (rsp_port.box_top),
      .box_right     (rsp_port.box_right),
      .box_bottom    (rsp_port.box_bottom),
      .union_left    (rsp_port.union_left),
      .union_top     (rsp_port.union_top),
      .union_right   (rsp_port.union_right),
      .union_bottom  (rsp_port.union_bottom)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock)
      (!reset && req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("request taken while a sprite is in progress");

   a_union_holds_box: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.union_left <= rsp_port.box_left &&
                          rsp_port.union_top <= rsp_port.box_top &&
                          rsp_port.union_right >= rsp_port.box_right &&
                          rsp_port.union_bottom >= rsp_port.box_bottom))
      else $error("union rectangle does not cover sprite box");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.box_left <= rsp_port.box_right &&
                          rsp_port.box_top <= rsp_port.box_bottom))
      else $error("sprite box edges out of order");
`endif

endmodule
